FILE: design/lz4bd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the lz4 block decompressor
package lz4bd_pkg;

    localparam int CNT_W          = 31;
    localparam int HIST_DEPTH_DEF = 65536;
    localparam int DIST_W         = 16;
    localparam int TDATA_IN_W     = 8;
    localparam int TDATA_OUT_W    = 40;
    localparam int TUSER_OUT_W    = 3;

    localparam logic [CNT_W-1:0] MAX_OUT_RESET = CNT_W'(65536);

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_START = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2,
        ST_BUSY = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_TOKEN  = 4'd1,
        PH_LITEXT = 4'd2,
        PH_LIT    = 4'd3,
        PH_OFFLO  = 4'd4,
        PH_OFFHI  = 4'd5,
        PH_MATEXT = 4'd6,
        PH_COPY   = 4'd7,
        PH_DONE   = 4'd8,
        PH_ERROR  = 4'd9
    } phase_t;

endpackage

FILE: design/lz4_block_decompressor.sv
`timescale 1ns / 1ps
// lz4 block decompressor top level
// Takes one beat per clock while the result register is free or being taken: a
// compressed byte, a copy tick or a block start, and returns exactly one result
// beat for each, through the input register, then the result register. The 64 KiB history is a single
// memory with one write and one registered read per cycle; the read for the
// next copy byte is issued from the updated state and a same-cycle write to
// that address is forwarded, so offset-1 copies run at full rate. The
// history needs no clearing pass; the block is ready right after reset.
module lz4_block_decompressor #(
    parameter int HISTORY_DEPTH = lz4bd_pkg::HIST_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // config
    input  logic                                cfg_wr_en,
    input  logic [lz4bd_pkg::CNT_W-1:0]         cfg_wr_data,   // max_output_bytes
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lz4bd_pkg::TDATA_IN_W-1:0]    s_axis_tdata,  // data_byte
    input  logic                                s_axis_tlast,  // last_byte
    input  logic [1:0]                          s_axis_tuser,  // cmd
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lz4bd_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,  // out_byte, bytes_written, pad
    output logic [lz4bd_pkg::TUSER_OUT_W-1:0]   m_axis_tuser   // out_valid, status
);
    import lz4bd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    // input register
    logic           in_valid_reg;
    logic [1:0]     in_cmd_reg;
    logic [7:0]     in_data_reg;
    logic           in_last_reg;

    // block state
    phase_t              phase_reg, phase_next;
    logic [CNT_W-1:0]    lit_reg, lit_next;
    logic [CNT_W-1:0]    ml_reg, ml_next;
    logic [DIST_W-1:0]   dist_reg, dist_next;
    logic [3:0]          nib_reg, nib_next;
    logic [CNT_W-1:0]    wc_reg, wc_next;
    logic                lseen_reg, lseen_next;
    logic [CNT_W-1:0]    max_reg;

    // result register
    logic                out_tvalid_reg;
    logic                oval_reg, oval_next;
    logic [7:0]          obyte_reg, obyte_next;
    logic [1:0]          ostat_reg, ostat_next;

    // history memory
    logic [7:0]     hist_mem [HISTORY_DEPTH];
    logic [7:0]     rd_data_reg;
    logic           byp_reg;
    logic [7:0]     byp_data_reg;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;
    logic           wr_en;
    logic [7:0]     hist_byte;

    logic             proc;
    logic [CNT_W-1:0] room;
    logic [CNT_W:0]   lsum;
    logic [CNT_W:0]   msum;
    logic [CNT_W:0]   msum4;
    logic [CNT_W-1:0] lit_dec;
    logic [CNT_W-1:0] ml_dec;
    logic [DIST_W-1:0] dist_full;

    assign proc          = in_valid_reg && (!out_tvalid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;

    assign room      = (max_reg > wc_reg) ? (max_reg - wc_reg) : '0;
    assign lsum      = {1'b0, lit_reg} + {{CNT_W-7{1'b0}}, in_data_reg};
    assign msum      = {1'b0, ml_reg} + {{CNT_W-7{1'b0}}, in_data_reg};
    assign msum4     = msum + (CNT_W+1)'(4);
    assign lit_dec   = lit_reg - CNT_W'(1);
    assign ml_dec    = ml_reg - CNT_W'(1);
    assign dist_full = {in_data_reg, dist_reg[7:0]};
    assign hist_byte = byp_reg ? byp_data_reg : rd_data_reg;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        lit_next   = lit_reg;
        ml_next    = ml_reg;
        dist_next  = dist_reg;
        nib_next   = nib_reg;
        wc_next    = wc_reg;
        lseen_next = lseen_reg;
        if (proc)
        begin
            if (in_cmd_reg == CMD_START)
            begin
                phase_next = PH_TOKEN;
                lit_next   = '0;
                ml_next    = '0;
                dist_next  = '0;
                nib_next   = '0;
                wc_next    = '0;
                lseen_next = 1'b0;
            end
            else if (in_cmd_reg == CMD_TICK)
            begin
                if (phase_reg == PH_COPY)
                begin
                    wc_next = wc_reg + CNT_W'(1);
                    ml_next = ml_dec;
                    if (ml_dec == '0)
                        phase_next = lseen_reg ? PH_DONE : PH_TOKEN;
                end
            end
            else if (in_cmd_reg == CMD_PUSH)
            begin
                case (phase_reg)
                    PH_IDLE, PH_COPY, PH_DONE, PH_ERROR:
                    begin
                        phase_next = phase_reg;
                    end
                    PH_TOKEN:
                    begin
                        nib_next = in_data_reg[3:0];
                        lit_next = CNT_W'(in_data_reg[7:4]);
                        if (in_data_reg[7:4] == 4'd15)
                        begin
                            if (in_last_reg || room < CNT_W'(15))
                                phase_next = PH_ERROR;
                            else
                                phase_next = PH_LITEXT;
                        end
                        else if (CNT_W'(in_data_reg[7:4]) > room)
                            phase_next = PH_ERROR;
                        else if (in_data_reg[7:4] == 4'd0)
                            phase_next = in_last_reg ? PH_DONE : PH_OFFLO;
                        else
                            phase_next = in_last_reg ? PH_ERROR : PH_LIT;
                    end
                    PH_LITEXT:
                    begin
                        lit_next = lsum[CNT_W-1:0];
                        if (lsum > {1'b0, room})
                            phase_next = PH_ERROR;
                        else if (in_data_reg == 8'hFF)
                        begin
                            if (in_last_reg)
                                phase_next = PH_ERROR;
                        end
                        else if (lsum == '0)
                            phase_next = in_last_reg ? PH_DONE : PH_OFFLO;
                        else
                            phase_next = in_last_reg ? PH_ERROR : PH_LIT;
                    end
                    PH_LIT:
                    begin
                        if (in_last_reg && lit_reg > CNT_W'(1))
                            phase_next = PH_ERROR;
                        else
                        begin
                            wc_next  = wc_reg + CNT_W'(1);
                            lit_next = lit_dec;
                            if (lit_dec == '0)
                                phase_next = in_last_reg ? PH_DONE : PH_OFFLO;
                        end
                    end
                    PH_OFFLO:
                    begin
                        dist_next  = DIST_W'(in_data_reg);
                        phase_next = in_last_reg ? PH_ERROR : PH_OFFHI;
                    end
                    PH_OFFHI:
                    begin
                        dist_next = dist_full;
                        if (dist_full == '0 || CNT_W'(dist_full) > wc_reg)
                            phase_next = PH_ERROR;
                        else if (nib_reg == 4'd15)
                        begin
                            ml_next = CNT_W'(15);
                            if (in_last_reg || room < CNT_W'(19))
                                phase_next = PH_ERROR;
                            else
                                phase_next = PH_MATEXT;
                        end
                        else
                        begin
                            ml_next = CNT_W'(nib_reg) + CNT_W'(4);
                            if (CNT_W'(nib_reg) + CNT_W'(4) > room)
                                phase_next = PH_ERROR;
                            else
                            begin
                                lseen_next = in_last_reg;
                                phase_next = PH_COPY;
                            end
                        end
                    end
                    PH_MATEXT:
                    begin
                        ml_next = msum[CNT_W-1:0];
                        if (msum4 > {1'b0, room})
                            phase_next = PH_ERROR;
                        else if (in_data_reg == 8'hFF)
                        begin
                            if (in_last_reg)
                                phase_next = PH_ERROR;
                        end
                        else
                        begin
                            ml_next    = msum4[CNT_W-1:0];
                            lseen_next = in_last_reg;
                            phase_next = PH_COPY;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_ERROR;
                    end
                endcase
            end
        end
    end

    // result fields
    always_comb
    begin
        oval_next  = 1'b0;
        obyte_next = '0;
        ostat_next = ST_RUN;
        if (in_cmd_reg == CMD_TICK && phase_reg == PH_COPY)
        begin
            oval_next  = 1'b1;
            obyte_next = hist_byte;
        end
        else if (in_cmd_reg == CMD_PUSH && phase_reg == PH_LIT && phase_next != PH_ERROR)
        begin
            oval_next  = 1'b1;
            obyte_next = in_data_reg;
        end

        if (in_cmd_reg == CMD_START)
            ostat_next = ST_RUN;
        else if (in_cmd_reg == CMD_PUSH && phase_reg == PH_COPY)
            ostat_next = ST_BUSY;
        else if (in_cmd_reg == CMD_PUSH && phase_reg == PH_IDLE)
            ostat_next = ST_ERR;
        else if (phase_next == PH_DONE)
            ostat_next = ST_DONE;
        else if (phase_next == PH_ERROR)
            ostat_next = ST_ERR;
        else
            ostat_next = ST_RUN;
    end

    // history write at the current count, read for the state that follows
    assign wr_en   = proc && oval_next;
    assign wr_addr = wc_reg[AW-1:0];
    assign rd_addr = wc_next[AW-1:0] - AW'(dist_next);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            hist_mem[wr_addr] <= obyte_next;
        rd_data_reg  <= hist_mem[rd_addr];
        byp_reg      <= wr_en && (wr_addr == rd_addr);
        byp_data_reg <= obyte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_tvalid_reg <= 1'b0;
            phase_reg      <= PH_IDLE;
            lit_reg        <= '0;
            ml_reg         <= '0;
            dist_reg       <= '0;
            nib_reg        <= '0;
            wc_reg         <= '0;
            lseen_reg      <= 1'b0;
            max_reg        <= MAX_OUT_RESET;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (proc)
                out_tvalid_reg <= 1'b1;
            else if (m_axis_tready)
                out_tvalid_reg <= 1'b0;
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            ml_reg    <= ml_next;
            dist_reg  <= dist_next;
            nib_reg   <= nib_next;
            wc_reg    <= wc_next;
            lseen_reg <= lseen_next;
            if (cfg_wr_en)
                max_reg <= cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (proc)
        begin
            oval_reg  <= oval_next;
            obyte_reg <= obyte_next;
            ostat_reg <= ostat_next;
        end
    end

    // bytes_written is the count after the beat, held with the result
    logic [CNT_W-1:0] bw_reg;
    always_ff @(posedge clk)
    begin
        if (proc)
            bw_reg <= wc_next;
    end

    assign m_axis_tvalid = out_tvalid_reg;
    assign m_axis_tdata  = {1'b0, bw_reg, obyte_reg};
    assign m_axis_tuser  = {ostat_reg, oval_reg};

endmodule

FILE: design/lz4bd_checker.sv
`timescale 1ns / 1ps
// port-level checks for the lz4 block decompressor, bound to the top level
module lz4bd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [lz4bd_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    input logic [lz4bd_pkg::TUSER_OUT_W-1:0]   m_axis_tuser
);
    import lz4bd_pkg::*;

    // a stalled result beat keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // a rejected push never carries a byte
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] == ST_BUSY |-> !m_axis_tuser[0])
        else $error("busy beat carries a byte");

    // no byte beat reports an error
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] != ST_ERR)
        else $error("byte emitted with error status");

    // an empty beat has a zero byte
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
        else $error("empty beat with nonzero byte");

endmodule

bind lz4_block_decompressor lz4bd_checker u_lz4bd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/tb_lz4_block_decompressor.sv
`timescale 1ns / 1ps
// self-checking testbench for the lz4 block decompressor, with a bytewise decode predictor
module tb_lz4_block_decompressor;
    import lz4bd_pkg::*;

    localparam logic [1:0] CMD_NOP     = 2'd3;  // unused command code, must change nothing
    localparam int         HOLD_CYCLES = 300;
    localparam int         SETTLE      = 8;
    // longest honest silence is the receiver hold-off, so this leaves a wide margin
    localparam int         STALL_LIMIT = 5000;

    typedef struct {
        logic        vld;
        logic [7:0]  data;
        status_t     st;
        logic [30:0] count;
    } out_beat_t;

    class decode_scoreboard;
        logic [30:0] capacity   = MAX_OUT_RESET;
        phase_t      phase      = PH_IDLE;
        logic [31:0] lit_left   = '0;
        logic [31:0] match_left = '0;
        logic [31:0] distance   = '0;
        logic [31:0] match_nib  = '0;
        logic [31:0] written    = '0;
        logic        last_seen  = 1'b0;
        logic [7:0]  history [HIST_DEPTH_DEF];
        out_beat_t   expected_beats[$];
        int n_in = 0, n_out = 0, n_err = 0, n_blocks = 0, n_done = 0, n_malformed = 0;

        function logic [31:0] room();
            return ({1'b0, capacity} > written) ? {1'b0, capacity} - written : 32'd0;
        endfunction

        function status_t settled_status();
            if (phase == PH_DONE)
                return ST_DONE;
            if (phase == PH_ERROR)
                return ST_ERR;
            return ST_RUN;
        endfunction

        function void put(logic [7:0] b);
            history[written[15:0]] = b;
            written = (written + 32'd1) & 32'h7FFF_FFFF;
        endfunction

        // offset complete: check it, then either copy or collect the length extension
        function void begin_match(logic l);
            if (distance == 32'd0 || distance > written) begin
                phase = PH_ERROR;
                return;
            end
            if (match_nib == 32'd15) begin
                match_left = 32'd15;
                if (l || match_left + 32'd4 > room())
                    phase = PH_ERROR;
                else
                    phase = PH_MATEXT;
                return;
            end
            match_left = match_nib + 32'd4;
            if (match_left > room())
                phase = PH_ERROR;
            else
            begin
                last_seen = l;
                phase = PH_COPY;
            end
        endfunction

        function void literals_known(logic l);
            if (lit_left > room())
                phase = PH_ERROR;
            else if (lit_left == 32'd0)
                phase = l ? PH_DONE : PH_OFFLO;
            else
                phase = l ? PH_ERROR : PH_LIT;
        endfunction

        function void note_input(logic [1:0] c, logic [7:0] b, logic l);
            phase_t    was;
            out_beat_t e;
            logic [15:0] src;
            was = phase;
            e.vld = 1'b0;
            e.data = 8'd0;
            e.st = ST_RUN;
            n_in++;
            if (c == CMD_START) begin
                phase = PH_TOKEN;
                lit_left = '0;
                match_left = '0;
                distance = '0;
                match_nib = '0;
                written = '0;
                last_seen = 1'b0;
                n_blocks++;
            end else if (c == CMD_PUSH) begin
                if (phase == PH_COPY)
                    e.st = ST_BUSY;
                else if (phase == PH_IDLE)
                    e.st = ST_ERR;
                else if (phase == PH_DONE || phase == PH_ERROR)
                    e.st = settled_status();
                else
                begin
                    case (phase)
                        PH_TOKEN: begin
                            match_nib = {28'd0, b[3:0]};
                            lit_left = {28'd0, b[7:4]};
                            if (lit_left == 32'd15) begin
                                if (l || lit_left > room())
                                    phase = PH_ERROR;
                                else
                                    phase = PH_LITEXT;
                            end else
                                literals_known(l);
                        end
                        PH_LITEXT: begin
                            lit_left += {24'd0, b};
                            if (lit_left > room())
                                phase = PH_ERROR;
                            else if (b == 8'hFF) begin
                                if (l)
                                    phase = PH_ERROR;
                            end else
                                literals_known(l);
                        end
                        PH_LIT: begin
                            if (l && lit_left > 32'd1)
                                phase = PH_ERROR;
                            else
                            begin
                                put(b);
                                e.vld = 1'b1;
                                e.data = b;
                                lit_left--;
                                if (lit_left == 32'd0)
                                    phase = l ? PH_DONE : PH_OFFLO;
                            end
                        end
                        PH_OFFLO: begin
                            distance = {24'd0, b};
                            phase = l ? PH_ERROR : PH_OFFHI;
                        end
                        PH_OFFHI: begin
                            distance = distance | {16'd0, b, 8'd0};
                            begin_match(l);
                        end
                        PH_MATEXT: begin
                            match_left += {24'd0, b};
                            if (match_left + 32'd4 > room())
                                phase = PH_ERROR;
                            else if (b == 8'hFF) begin
                                if (l)
                                    phase = PH_ERROR;
                            end else
                            begin
                                match_left += 32'd4;
                                last_seen = l;
                                phase = PH_COPY;
                            end
                        end
                        default: phase = PH_ERROR;
                    endcase
                    if (phase == PH_ERROR) begin
                        e.vld = 1'b0;
                        e.data = 8'd0;
                    end
                    e.st = settled_status();
                end
            end else if (c == CMD_TICK && phase == PH_COPY) begin
                // ring read: overlapping copies repeat the bytes just written
                src = 16'(written - distance);
                e.data = history[src];
                put(e.data);
                e.vld = 1'b1;
                match_left--;
                if (match_left == 32'd0)
                    phase = last_seen ? PH_DONE : PH_TOKEN;
                e.st = settled_status();
            end else
                e.st = settled_status();
            if (was != phase && phase == PH_DONE)
                n_done++;
            if (was != phase && phase == PH_ERROR)
                n_malformed++;
            e.count = written[30:0];
            expected_beats.push_back(e);
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        task report(string msg);
            n_err++;
            $display("mismatch: %s", msg);
        endtask

        task check_result(logic v, logic [7:0] d, logic [1:0] st, logic [30:0] cnt);
            out_beat_t e;
            if (expected_beats.size() == 0) begin
                report("result beat arrived with nothing expected");
                return;
            end
            e = expected_beats.pop_front();
            n_out++;
            if (v !== e.vld)
                report($sformatf("beat %0d out_valid %b, want %b", n_out, v, e.vld));
            if (d !== e.data)
                report($sformatf("beat %0d out_byte %h, want %h", n_out, d, e.data));
            if (st !== e.st)
                report($sformatf("beat %0d status %0d, want %0d", n_out, st, e.st));
            if (cnt !== e.count)
                report($sformatf("beat %0d bytes_written %0d, want %0d", n_out, cnt, e.count));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]       cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;   // data_byte
    logic                   s_axis_tlast = 1'b0; // last_byte
    logic [1:0]             s_axis_tuser = '0;   // cmd
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;        // out_byte, bytes_written, pad
    logic [TUSER_OUT_W-1:0] m_axis_tuser;        // out_valid, status

    decode_scoreboard sb = new;
    int send_idle_pct = 38;
    int recv_idle_pct = 55;
    int hold_left = 0;
    int stall_cycles = 0;
    int cfg_writes = 0;
    bit hold_req = 1'b0;

    lz4_block_decompressor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // receiver: random back-pressure, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tuser[2:1],
                            m_axis_tdata[38:8]);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("timeout with %0d result beats outstanding", sb.pending());
            $display("status: fail");
            $finish;
        end
    end

    // one beat: random gaps before it, valid held until accepted
    task automatic send(logic [1:0] c, logic [7:0] b, logic l);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= l;
        s_axis_tuser <= c;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(c, b, l);
    endtask

    task automatic push(logic [7:0] b, logic l);
        send(CMD_PUSH, b, l);
    endtask

    task automatic copy_out();
        while (sb.phase == PH_COPY)
            send(CMD_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_capacity(logic [30:0] v);
        wait_idle();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.capacity = v;
        cfg_writes++;
    endtask

    task automatic run_directed();
        push(8'hA5, 1'b1);                  // no block open yet
        send(CMD_NOP, 8'hFF, 1'b1);
        send(CMD_START, 8'h00, 1'b0);
        push(8'h23, 1'b0);                  // two literals, match of seven
        push(8'hFF, 1'b0);
        push(8'h00, 1'b0);
        push(8'h01, 1'b0);                  // offset one: copy overlaps itself
        push(8'h00, 1'b0);
        push(8'h77, 1'b0);                  // rejected while copying
        copy_out();
        push(8'h10, 1'b0);
        push(8'h5A, 1'b1);                  // literal ends the block
        push(8'h33, 1'b0);                  // ignored after finish
        send(CMD_TICK, 8'h5A, 1'b1);
        send(CMD_START, 8'hFF, 1'b1);
        push(8'h0F, 1'b0);                  // zero offset
        push(8'h00, 1'b0);
        push(8'h00, 1'b0);
        send(CMD_START, 8'h00, 1'b0);
        push(8'h00, 1'b1);                  // empty block
        send(CMD_START, 8'h00, 1'b0);
        push(8'h10, 1'b1);                  // truncated right after the token
        send(CMD_START, 8'h00, 1'b0);
        push(8'h1F, 1'b0);                  // extended match length, block ends on it
        push(8'hC3, 1'b0);
        push(8'h01, 1'b0);
        push(8'h00, 1'b0);
        push(8'h01, 1'b1);
        copy_out();
    endtask

    // one block of well-formed sequences with random content, a few of them broken
    task automatic gen_block();
        int nseq, r, lit_len, ext, brk, avail, off;
        logic [3:0] lit_nib, mat_nib;
        logic [7:0] b;
        logic ending, on_lit;
        nseq = $urandom_range(1, 5);
        off = 1;
        send(CMD_START, 8'($urandom), 1'($urandom));
        for (int s = 0; s < nseq; s++) begin
            if (sb.phase != PH_TOKEN)
                break;
            ending = (s == nseq - 1);
            on_lit = ending && ($urandom_range(0, 1) == 0);
            brk = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 7) : 0;
            r = $urandom_range(0, 99);
            if (r < 12)
                lit_len = 0;
            else if (r < 80)
                lit_len = $urandom_range(1, 14);
            else if (r < 96)
                lit_len = $urandom_range(15, 60);
            else
                lit_len = 270 + $urandom_range(0, 20);
            // a first match needs history behind it
            if (lit_len == 0 && !on_lit && sb.written == 32'd0 && brk == 0)
                lit_len = 1;
            lit_nib = (lit_len >= 15) ? 4'hF : 4'(lit_len);
            mat_nib = ($urandom_range(0, 99) < 20) ? 4'hF : 4'($urandom_range(0, 14));
            push({lit_nib, mat_nib}, (on_lit && lit_len == 0) || brk == 1);
            ext = lit_len - 15;
            while (sb.phase == PH_LITEXT) begin
                b = (ext >= 255) ? 8'hFF : 8'(ext);
                ext -= 255;
                push(b, brk == 2);
            end
            while (sb.phase == PH_LIT)
                push(8'($urandom), (sb.lit_left == 32'd1) ? on_lit
                                   : (brk == 3 && $urandom_range(0, 3) == 0));
            if (brk == 6 && sb.phase == PH_OFFLO)
                send(CMD_START, 8'($urandom), 1'($urandom));
            if (sb.phase == PH_OFFLO) begin
                avail = (sb.written > 32'd65535) ? 65535 : int'(sb.written);
                if (brk == 4)
                    off = 0;
                else if (brk == 5)
                    off = (avail >= 65535) ? 0
                          : $urandom_range(avail + 1, (avail + 50 > 65535) ? 65535 : avail + 50);
                else if (avail == 0)
                    off = 1;
                else if ($urandom_range(0, 1) == 0)
                    off = $urandom_range(1, (avail < 8) ? avail : 8);
                else
                    off = $urandom_range(1, avail);
                push(8'(off), brk == 7);
            end
            if (sb.phase == PH_OFFHI)
                push(8'(off >> 8), ending && !on_lit && mat_nib != 4'hF);
            ext = ($urandom_range(0, 99) < 96) ? $urandom_range(0, 40)
                                               : 255 + $urandom_range(0, 10);
            while (sb.phase == PH_MATEXT) begin
                b = (ext >= 255) ? 8'hFF : 8'(ext);
                ext -= 255;
                push(b, ending && !on_lit && b != 8'hFF);
            end
            while (sb.phase == PH_COPY) begin
                if ($urandom_range(0, 99) < 8)
                    push(8'($urandom), 1'($urandom));
                else
                    send(CMD_TICK, 8'($urandom), 1'($urandom));
            end
        end
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 3))
                send(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        set_capacity(31'h7FFF_FFFF);
        while (sb.n_in < 450)
            gen_block();
        set_capacity(31'd0);
        while (sb.n_in < 520)
            gen_block();

        send_idle_pct = 55;
        recv_idle_pct = 38;
        set_capacity(31'($urandom_range(24, 120)));
        while (sb.n_in < 900)
            gen_block();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_capacity(MAX_OUT_RESET);
        // receiver stalls while the sender keeps streaming, so the pipe backs up
        hold_req = 1'b1;
        repeat (3) gen_block();
        wait_idle();
        while (sb.n_in < 1250)
            gen_block();

        wait_idle();
        $display("covered %0d input beats and %0d result beats over %0d blocks",
                 sb.n_in, sb.n_out, sb.n_blocks);
        $display("capacity writes %0d, blocks finished cleanly %0d, malformed %0d, mismatches %0d",
                 cfg_writes, sb.n_done, sb.n_malformed, sb.n_err);
        if (sb.n_err == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
